// File: rtl/nsp_pkg.sv
package nsp_pkg;

   // Table size and projection parameter format.
   localparam int MAX_SEGMENTS = 1024;
   localparam int T_FRAC_BITS  = 16;

   // Field widths.
   localparam int COORD_W   = 24;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int SUM_W     = 2 * DIFF_W + 1;
   localparam int DIST_W    = 50;
   localparam int IDX_OUT_W = 10;
   localparam int ADDR_W    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W     = $clog2(MAX_SEGMENTS + 1);
   localparam int T_W       = T_FRAC_BITS + 1;
   localparam int TPROD_W   = T_W + 1 + DIFF_W;

   // Function codes of an input item.
   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_LOAD  = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;
   localparam logic [1:0] FUNC_NONE  = 2'd3;

   // One segment read from the table.
   typedef struct packed {
      logic                       valid;
      logic                       last;
      logic [ADDR_W-1:0]          idx;
      logic signed [COORD_W-1:0]  ax;
      logic signed [COORD_W-1:0]  ay;
      logic signed [COORD_W-1:0]  bx;
      logic signed [COORD_W-1:0]  by;
   } seg_type;

   // State passed between divider cells.
   typedef struct packed {
      logic                       valid;
      logic                       last;
      logic [ADDR_W-1:0]          idx;
      logic signed [COORD_W-1:0]  ax;
      logic signed [COORD_W-1:0]  ay;
      logic signed [DIFF_W-1:0]   dx;
      logic signed [DIFF_W-1:0]   dy;
      logic [SUM_W-1:0]           rem;
      logic [SUM_W-1:0]           den;
      logic [T_FRAC_BITS-1:0]     q;
      logic                       sat;
   } div_type;

   // One projected candidate.
   typedef struct packed {
      logic                       valid;
      logic                       last;
      logic [ADDR_W-1:0]          idx;
      logic signed [COORD_W-1:0]  px;
      logic signed [COORD_W-1:0]  py;
      logic [DIST_W-1:0]          dist_sq;
   } cand_type;

endpackage

// File: rtl/nsp_if.sv
interface nsp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [23:0] start_x;
   logic signed [23:0] start_y;
   logic signed [23:0] end_x;
   logic signed [23:0] end_y;
   logic signed [23:0] point_x;
   logic signed [23:0] point_y;

   modport source (output valid, func, start_x, start_y, end_x, end_y, point_x, point_y,
                   input ready);
   modport sink (input valid, func, start_x, start_y, end_x, end_y, point_x, point_y,
                 output ready);
endinterface

interface nsp_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   logic [9:0]         segment_index;
   logic signed [23:0] nearest_x;
   logic signed [23:0] nearest_y;
   logic [49:0]        distance_sq;

   modport source (output valid, found, segment_index, nearest_x, nearest_y, distance_sq,
                   input ready);
   modport sink (input valid, found, segment_index, nearest_x, nearest_y, distance_sq,
                 output ready);
endinterface

// File: rtl/nsp_div_cell.sv
module nsp_div_cell (
   input  logic            clock,
   input  logic            reset,
   input  nsp_pkg::div_type cell_in,
   output nsp_pkg::div_type cell_out
);
   import nsp_pkg::*;

   logic [SUM_W-1:0] rem_shift;
   logic             ge;
   div_type          cell_ff;
   div_type          cell_in_nxt;

   // One restoring division step: shift, compare, subtract.
   always_comb begin
      rem_shift       = {cell_in.rem[SUM_W-2:0], 1'b0};
      ge              = (rem_shift >= cell_in.den);
      cell_in_nxt     = cell_in;
      cell_in_nxt.rem = ge ? (rem_shift - cell_in.den) : rem_shift;
      cell_in_nxt.q   = {cell_in.q[T_FRAC_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in_nxt;
      end
   end

   assign cell_out = cell_ff;
endmodule

// File: rtl/nsp_proj_pipe.sv
module nsp_proj_pipe (
   input  logic                               clock,
   input  logic                               reset,
   input  nsp_pkg::seg_type                   seg,
   input  logic signed [nsp_pkg::COORD_W-1:0] qx,
   input  logic signed [nsp_pkg::COORD_W-1:0] qy,
   output nsp_pkg::cand_type                  cand
);
   import nsp_pkg::*;

   // Stage 1: differences.
   logic                      s1_vld_ff, s1_last_ff;
   logic [ADDR_W-1:0]         s1_idx_ff;
   logic signed [COORD_W-1:0] s1_ax_ff, s1_ay_ff;
   logic signed [DIFF_W-1:0]  s1_dx_ff, s1_dy_ff, s1_ex_ff, s1_ey_ff;

   always_ff @(posedge clock) begin
      s1_idx_ff <= seg.idx;
      s1_last_ff <= seg.last;
      s1_ax_ff  <= seg.ax;
      s1_ay_ff  <= seg.ay;
      s1_dx_ff  <= DIFF_W'(seg.bx) - DIFF_W'(seg.ax);
      s1_dy_ff  <= DIFF_W'(seg.by) - DIFF_W'(seg.ay);
      s1_ex_ff  <= DIFF_W'(qx) - DIFF_W'(seg.ax);
      s1_ey_ff  <= DIFF_W'(qy) - DIFF_W'(seg.ay);
      if (reset) s1_vld_ff <= 1'b0;
      else       s1_vld_ff <= seg.valid;
   end

   // Stage 2: products for length and dot product.
   logic                        s2_vld_ff, s2_last_ff;
   logic [ADDR_W-1:0]           s2_idx_ff;
   logic signed [COORD_W-1:0]   s2_ax_ff, s2_ay_ff;
   logic signed [DIFF_W-1:0]    s2_dx_ff, s2_dy_ff;
   logic signed [2*DIFF_W-1:0]  s2_xx_ff, s2_yy_ff, s2_xd_ff, s2_yd_ff;

   always_ff @(posedge clock) begin
      s2_idx_ff  <= s1_idx_ff;
      s2_last_ff <= s1_last_ff;
      s2_ax_ff   <= s1_ax_ff;
      s2_ay_ff   <= s1_ay_ff;
      s2_dx_ff   <= s1_dx_ff;
      s2_dy_ff   <= s1_dy_ff;
      s2_xx_ff   <= s1_dx_ff * s1_dx_ff;
      s2_yy_ff   <= s1_dy_ff * s1_dy_ff;
      s2_xd_ff   <= s1_ex_ff * s1_dx_ff;
      s2_yd_ff   <= s1_ey_ff * s1_dy_ff;
      if (reset) s2_vld_ff <= 1'b0;
      else       s2_vld_ff <= s1_vld_ff;
   end

   // Stage 3: squared length and dot product.
   logic                      s3_vld_ff, s3_last_ff;
   logic [ADDR_W-1:0]         s3_idx_ff;
   logic signed [COORD_W-1:0] s3_ax_ff, s3_ay_ff;
   logic signed [DIFF_W-1:0]  s3_dx_ff, s3_dy_ff;
   logic signed [SUM_W-1:0]   s3_len2_ff, s3_dot_ff;

   always_ff @(posedge clock) begin
      s3_idx_ff  <= s2_idx_ff;
      s3_last_ff <= s2_last_ff;
      s3_ax_ff   <= s2_ax_ff;
      s3_ay_ff   <= s2_ay_ff;
      s3_dx_ff   <= s2_dx_ff;
      s3_dy_ff   <= s2_dy_ff;
      s3_len2_ff <= SUM_W'(s2_xx_ff) + SUM_W'(s2_yy_ff);
      s3_dot_ff  <= SUM_W'(s2_xd_ff) + SUM_W'(s2_yd_ff);
      if (reset) s3_vld_ff <= 1'b0;
      else       s3_vld_ff <= s2_vld_ff;
   end

   // Stage 4: clamp decision and divider setup.
   logic    zero_t, sat_t;
   div_type setup_in;
   div_type setup_ff;

   always_comb begin
      zero_t         = (s3_len2_ff == '0) || (s3_dot_ff <= 0);
      sat_t          = !zero_t && (s3_dot_ff >= s3_len2_ff);
      setup_in.valid = s3_vld_ff;
      setup_in.last  = s3_last_ff;
      setup_in.idx   = s3_idx_ff;
      setup_in.ax    = s3_ax_ff;
      setup_in.ay    = s3_ay_ff;
      setup_in.dx    = s3_dx_ff;
      setup_in.dy    = s3_dy_ff;
      setup_in.q     = '0;
      setup_in.sat   = sat_t;
      if (zero_t || sat_t) begin
         setup_in.rem = '0;
         setup_in.den = SUM_W'(1);
      end else begin
         setup_in.rem = s3_dot_ff;
         setup_in.den = s3_len2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) setup_ff <= '0;
      else       setup_ff <= setup_in;
   end

   // Chain of divider cells, one quotient bit each.
   div_type chain [T_FRAC_BITS+1];
   assign chain[0] = setup_ff;

   for (genvar i = 0; i < T_FRAC_BITS; i++) begin : g_cell
      nsp_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   // Stage 5: scale the deltas by the parameter.
   div_type                   dq;
   logic [T_W-1:0]            t_val;
   logic                      s5_vld_ff, s5_last_ff;
   logic [ADDR_W-1:0]         s5_idx_ff;
   logic signed [COORD_W-1:0] s5_ax_ff, s5_ay_ff;
   logic signed [TPROD_W-1:0] s5_px_ff, s5_py_ff;

   assign dq    = chain[T_FRAC_BITS];
   assign t_val = dq.sat ? (T_W'(1) << T_FRAC_BITS) : {1'b0, dq.q};

   always_ff @(posedge clock) begin
      s5_idx_ff  <= dq.idx;
      s5_last_ff <= dq.last;
      s5_ax_ff   <= dq.ax;
      s5_ay_ff   <= dq.ay;
      s5_px_ff   <= $signed({1'b0, t_val}) * dq.dx;
      s5_py_ff   <= $signed({1'b0, t_val}) * dq.dy;
      if (reset) s5_vld_ff <= 1'b0;
      else       s5_vld_ff <= dq.valid;
   end

   // Stage 6: floored shift and offset from the start point.
   logic signed [TPROD_W-1:0] shx, shy;
   logic signed [DIFF_W-1:0]  sumx, sumy;
   logic                      s6_vld_ff, s6_last_ff;
   logic [ADDR_W-1:0]         s6_idx_ff;
   logic signed [COORD_W-1:0] s6_px_ff, s6_py_ff;

   always_comb begin
      shx  = s5_px_ff >>> T_FRAC_BITS;
      shy  = s5_py_ff >>> T_FRAC_BITS;
      sumx = DIFF_W'(s5_ax_ff) + shx[DIFF_W-1:0];
      sumy = DIFF_W'(s5_ay_ff) + shy[DIFF_W-1:0];
   end

   always_ff @(posedge clock) begin
      s6_idx_ff  <= s5_idx_ff;
      s6_last_ff <= s5_last_ff;
      s6_px_ff   <= sumx[COORD_W-1:0];
      s6_py_ff   <= sumy[COORD_W-1:0];
      if (reset) s6_vld_ff <= 1'b0;
      else       s6_vld_ff <= s5_vld_ff;
   end

   // Stage 7: error vector.
   logic                      s7_vld_ff, s7_last_ff;
   logic [ADDR_W-1:0]         s7_idx_ff;
   logic signed [COORD_W-1:0] s7_px_ff, s7_py_ff;
   logic signed [DIFF_W-1:0]  s7_ex_ff, s7_ey_ff;

   always_ff @(posedge clock) begin
      s7_idx_ff  <= s6_idx_ff;
      s7_last_ff <= s6_last_ff;
      s7_px_ff   <= s6_px_ff;
      s7_py_ff   <= s6_py_ff;
      s7_ex_ff   <= DIFF_W'(qx) - DIFF_W'(s6_px_ff);
      s7_ey_ff   <= DIFF_W'(qy) - DIFF_W'(s6_py_ff);
      if (reset) s7_vld_ff <= 1'b0;
      else       s7_vld_ff <= s6_vld_ff;
   end

   // Stage 8: squares of the error.
   logic                       s8_vld_ff, s8_last_ff;
   logic [ADDR_W-1:0]          s8_idx_ff;
   logic signed [COORD_W-1:0]  s8_px_ff, s8_py_ff;
   logic signed [2*DIFF_W-1:0] s8_sx_ff, s8_sy_ff;

   always_ff @(posedge clock) begin
      s8_idx_ff  <= s7_idx_ff;
      s8_last_ff <= s7_last_ff;
      s8_px_ff   <= s7_px_ff;
      s8_py_ff   <= s7_py_ff;
      s8_sx_ff   <= s7_ex_ff * s7_ex_ff;
      s8_sy_ff   <= s7_ey_ff * s7_ey_ff;
      if (reset) s8_vld_ff <= 1'b0;
      else       s8_vld_ff <= s7_vld_ff;
   end

   // Stage 9: squared distance.
   cand_type cand_ff;

   always_ff @(posedge clock) begin
      cand_ff.idx     <= s8_idx_ff;
      cand_ff.last    <= s8_last_ff;
      cand_ff.px      <= s8_px_ff;
      cand_ff.py      <= s8_py_ff;
      cand_ff.dist_sq <= DIST_W'(s8_sx_ff) + DIST_W'(s8_sy_ff);
      if (reset) cand_ff.valid <= 1'b0;
      else       cand_ff.valid <= s8_vld_ff;
   end

   assign cand = cand_ff;
endmodule

// File: rtl/nearest_segment_projection.sv
// Nearest point search over a table of line segments.
// The req channel carries items with a function code: clear empties the
// table, load appends one segment (dropped when the table is full), and
// query searches every stored segment for the nearest projected point.
// Clear and load produce no result. A query
// produces exactly one item on the rsp channel.
// A query reads one segment per cycle from the table memory into a
// pipeline of 25 stages, 16 of them a row of division cells that form the
// projection parameter one bit each. A query streams the N stored
// segments through the single table read port; an empty table answers
// with found low.
// Reset empties the table and drops any pending result.
// The result is held in an output register until rsp is taken; loads and
// clears are still accepted meanwhile, and a following query runs its scan
// but waits at its end until the earlier result has left.
module nearest_segment_projection (
   input  logic      clock,
   input  logic      reset,
   nsp_req_if.sink   req_chan,
   nsp_rsp_if.source rsp_chan
);
   import nsp_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_WAIT   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          scan_ff, scan_in;
   logic signed [COORD_W-1:0] qx_ff, qy_ff;
   logic                      req_fire, issue, issue_last, wr_en, start_q;

   // Table memory.
   logic [4*COORD_W-1:0] mem [MAX_SEGMENTS];
   logic [4*COORD_W-1:0] rd_data_ff;
   logic                 rd_vld_ff, rd_last_ff;
   logic [ADDR_W-1:0]    rd_idx_ff;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign wr_en      = req_fire && (req_chan.func == FUNC_LOAD) &&
                       (count_ff < CNT_W'(MAX_SEGMENTS));
   assign start_q    = req_fire && (req_chan.func == FUNC_QUERY);
   assign issue      = (state_ff == S_SCAN);
   assign issue_last = (scan_ff == count_ff - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[ADDR_W-1:0]] <= {req_chan.start_x, req_chan.start_y,
                                       req_chan.end_x, req_chan.end_y};
      end
      rd_data_ff <= mem[scan_ff[ADDR_W-1:0]];
      rd_idx_ff  <= scan_ff[ADDR_W-1:0];
      rd_last_ff <= issue_last;
      if (reset) rd_vld_ff <= 1'b0;
      else       rd_vld_ff <= issue;
   end

   // Projection pipeline.
   seg_type  seg;
   cand_type cand;

   always_comb begin
      seg.valid = rd_vld_ff;
      seg.last  = rd_last_ff;
      seg.idx   = rd_idx_ff;
      seg.ax    = rd_data_ff[4*COORD_W-1:3*COORD_W];
      seg.ay    = rd_data_ff[3*COORD_W-1:2*COORD_W];
      seg.bx    = rd_data_ff[2*COORD_W-1:COORD_W];
      seg.by    = rd_data_ff[COORD_W-1:0];
   end

   nsp_proj_pipe u_pipe (
      .clock (clock),
      .reset (reset),
      .seg   (seg),
      .qx    (qx_ff),
      .qy    (qy_ff),
      .cand  (cand)
   );

   // Control sequencer.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      scan_in  = scan_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_chan.func == FUNC_CLEAR) count_in = '0;
               if (wr_en) count_in = count_ff + CNT_W'(1);
               if (start_q) begin
                  scan_in  = '0;
                  state_in = (count_ff == '0) ? S_FINISH : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            scan_in = scan_ff + CNT_W'(1);
            if (issue_last) state_in = S_WAIT;
         end
         S_WAIT: begin
            if (cand.valid && cand.last) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_chan.valid || rsp_chan.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         scan_ff  <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start_q) begin
         qx_ff <= req_chan.point_x;
         qy_ff <= req_chan.point_y;
      end
   end

   // Running best candidate; the first strictly smaller distance wins.
   logic                      have_ff;
   logic [ADDR_W-1:0]         best_idx_ff;
   logic signed [COORD_W-1:0] best_x_ff, best_y_ff;
   logic [DIST_W-1:0]         best_d_ff;

   always_ff @(posedge clock) begin
      if (reset || start_q) begin
         have_ff     <= 1'b0;
         best_idx_ff <= '0;
         best_x_ff   <= '0;
         best_y_ff   <= '0;
         best_d_ff   <= '0;
      end else if (cand.valid && (!have_ff || cand.dist_sq < best_d_ff)) begin
         have_ff     <= 1'b1;
         best_idx_ff <= cand.idx;
         best_x_ff   <= cand.px;
         best_y_ff   <= cand.py;
         best_d_ff   <= cand.dist_sq;
      end
   end

   // Output register.
   logic                      rsp_vld_ff;
   logic                      rsp_found_ff;
   logic [IDX_OUT_W-1:0]      rsp_idx_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [DIST_W-1:0]         rsp_d_ff;
   logic                      rsp_load;

   assign rsp_load = (state_ff == S_FINISH) && (!rsp_vld_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= have_ff;
         rsp_idx_ff   <= IDX_OUT_W'(best_idx_ff);
         rsp_x_ff     <= best_x_ff;
         rsp_y_ff     <= best_y_ff;
         rsp_d_ff     <= best_d_ff;
      end
      if (reset)              rsp_vld_ff <= 1'b0;
      else if (rsp_load)      rsp_vld_ff <= 1'b1;
      else if (rsp_chan.ready) rsp_vld_ff <= 1'b0;
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.found         = rsp_found_ff;
   assign rsp_chan.segment_index = rsp_idx_ff;
   assign rsp_chan.nearest_x     = rsp_x_ff;
   assign rsp_chan.nearest_y     = rsp_y_ff;
   assign rsp_chan.distance_sq   = rsp_d_ff;
endmodule
